// ===== sv/spi_pkg.sv =====
// Package for spectral_peak_impedance: shared types, status codes and the
// CORDIC angle table. No dependencies.
`default_nettype none
package spi_pkg;

    localparam int PHASE_W = 16;
    localparam int ITERS   = 16;

    typedef enum logic [1:0] {
        ST_MATCH    = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_NO_PEAK  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } fsm_t;

    function automatic logic [PHASE_W-1:0] atan_tab(input logic [3:0] i);
        logic [PHASE_W-1:0] r;
        begin
            case (i)
                4'd0:    r = 16'd8192;
                4'd1:    r = 16'd4836;
                4'd2:    r = 16'd2555;
                4'd3:    r = 16'd1297;
                4'd4:    r = 16'd651;
                4'd5:    r = 16'd326;
                4'd6:    r = 16'd163;
                4'd7:    r = 16'd81;
                4'd8:    r = 16'd41;
                4'd9:    r = 16'd20;
                4'd10:   r = 16'd10;
                4'd11:   r = 16'd5;
                4'd12:   r = 16'd3;
                4'd13:   r = 16'd1;
                4'd14:   r = 16'd1;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/spi_lane.sv =====
// One channel lane: iterative integer square root and CORDIC phase, then
// strict local-maximum peak tracking. Depends on spi_pkg.
`default_nettype none
module spi_lane #(
    parameter int SW = 24,
    parameter int BW = 9
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       clear,
    input  wire logic                       track_en,
    input  wire logic                       zero_mag,
    input  wire logic [BW-1:0]              bin,
    input  wire logic signed [SW-1:0]       re,
    input  wire logic signed [SW-1:0]       im,
    output logic                            done,
    output logic [SW:0]                     best_mag,
    output logic [BW-1:0]                   best_idx,
    output logic signed [spi_pkg::PHASE_W-1:0] best_ph
);
    import spi_pkg::*;

    localparam int SQW = 2 * SW + 2;   // re^2+im^2 width (padded even)
    localparam int MW  = SW + 1;
    localparam int XW  = SW + 11;      // scaled operand plus CORDIC growth
    localparam int SCW = $clog2(MW + 1);

    logic            busy_reg, busy_next;
    logic [SCW-1:0]  scnt_reg, scnt_next;
    logic [3:0]      ccnt_reg, ccnt_next;
    logic            cdone_reg, cdone_next;
    logic [SQW-1:0]  rem_reg, rem_next;
    logic [MW-1:0]   root_reg, root_next;
    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic [PHASE_W-1:0] z_reg, z_next;
    logic            fixed_reg, fixed_next;
    logic            zm_reg, zm_next;
    logic            trk_reg, trk_next;
    logic [BW-1:0]   bin_reg, bin_next;
    logic            done_reg, done_next;

    logic [MW-1:0]   p0_reg, p0_next, p1_reg, p1_next;
    logic [PHASE_W-1:0] pph_reg, pph_next;
    logic [MW-1:0]   bm_reg, bm_next;
    logic [BW-1:0]   bi_reg, bi_next;
    logic [PHASE_W-1:0] bp_reg, bp_next;

    logic [SW-1:0]   are, aim;
    logic [SQW-1:0]  sq;
    logic [SQW-1:0]  trial;
    logic [SQW-1:0]  rem_sh;
    logic signed [XW-1:0] xs, ys;
    logic            sdone;
    logic [MW-1:0]   cur_mag;

    assign are = re[SW-1] ? SW'(-re) : SW'(re);
    assign aim = im[SW-1] ? SW'(-im) : SW'(im);
    assign sq  = SQW'(are) * SQW'(are) + SQW'(aim) * SQW'(aim);

    // restoring square root: two radicand bits per step
    assign rem_sh = {rem_reg[SQW-3:0], 2'b00};
    assign trial  = SQW'({root_reg, 2'b01});
    assign sdone  = (scnt_reg == SCW'(0));
    assign cur_mag = zm_reg ? '0 : root_reg;

    logic [SQW-1:0] rad_reg, rad_next;

    always_comb
    begin
        busy_next  = busy_reg;
        scnt_next  = scnt_reg;
        ccnt_next  = ccnt_reg;
        cdone_next = cdone_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        rad_next   = rad_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        fixed_next = fixed_reg;
        zm_next    = zm_reg;
        trk_next   = trk_reg;
        bin_next   = bin_reg;
        done_next  = 1'b0;
        p0_next = p0_reg; p1_next = p1_reg; pph_next = pph_reg;
        bm_next = bm_reg; bi_next = bi_reg; bp_next = bp_reg;
        xs = x_reg >>> ccnt_reg;
        ys = y_reg >>> ccnt_reg;

        if (start)
        begin
            busy_next  = 1'b1;
            scnt_next  = SCW'(SQW / 2);
            ccnt_next  = 4'd0;
            cdone_next = 1'b0;
            rem_next   = '0;
            root_next  = '0;
            rad_next   = sq;
            zm_next    = zero_mag;
            trk_next   = track_en;
            bin_next   = bin;
            fixed_next = 1'b1;
            if (im == '0)
                z_next = re[SW-1] ? 16'h8000 : 16'h0000;
            else if (re == '0)
                z_next = im[SW-1] ? 16'hC000 : 16'h4000;
            else
            begin
                fixed_next = 1'b0;
                if (re[SW-1])
                begin
                    x_next = -(XW'(re) <<< 8);
                    y_next = -(XW'(im) <<< 8);
                    z_next = 16'h8000;
                end
                else
                begin
                    x_next = XW'(re) <<< 8;
                    y_next = XW'(im) <<< 8;
                    z_next = 16'h0000;
                end
            end
        end
        else if (busy_reg)
        begin
            if (!sdone)
            begin
                scnt_next = scnt_reg - SCW'(1);
                rad_next  = {rad_reg[SQW-3:0], 2'b00};
                if ((rem_sh | SQW'(rad_reg[SQW-1 -: 2])) >= trial)
                begin
                    rem_next  = (rem_sh | SQW'(rad_reg[SQW-1 -: 2])) - trial;
                    root_next = {root_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh | SQW'(rad_reg[SQW-1 -: 2]);
                    root_next = {root_reg[MW-2:0], 1'b0};
                end
            end
            if (!cdone_reg)
            begin
                if (!fixed_reg)
                begin
                    if (y_reg > XW'(0))
                    begin
                        x_next = x_reg + ys;
                        y_next = y_reg - xs;
                        z_next = z_reg + atan_tab(ccnt_reg);
                    end
                    else
                    begin
                        x_next = x_reg - ys;
                        y_next = y_reg + xs;
                        z_next = z_reg - atan_tab(ccnt_reg);
                    end
                end
                ccnt_next = ccnt_reg + 4'd1;
                if (ccnt_reg == 4'd15)
                    cdone_next = 1'b1;
            end
            if (sdone && cdone_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (trk_reg && p1_reg < p0_reg && p0_reg > cur_mag && p0_reg > bm_reg)
                begin
                    bm_next = p0_reg;
                    bi_next = BW'(bin_reg - BW'(1));
                    bp_next = pph_reg;
                end
                p1_next  = p0_reg;
                p0_next  = cur_mag;
                pph_next = z_reg;
            end
        end
        if (clear)
        begin
            p0_next = '0; p1_next = '0; pph_next = '0;
            bm_next = '0; bi_next = '0; bp_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
            p0_reg <= '0; p1_reg <= '0; pph_reg <= '0;
            bm_reg <= '0; bi_reg <= '0; bp_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next;
            p0_reg <= p0_next; p1_reg <= p1_next; pph_reg <= pph_next;
            bm_reg <= bm_next; bi_reg <= bi_next; bp_reg <= bp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scnt_reg <= scnt_next; ccnt_reg <= ccnt_next; cdone_reg <= cdone_next;
        rem_reg <= rem_next; root_reg <= root_next; rad_reg <= rad_next;
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        fixed_reg <= fixed_next; zm_reg <= zm_next; trk_reg <= trk_next;
        bin_reg <= bin_next;
    end

    assign done     = done_reg;
    assign best_mag = bm_reg;
    assign best_idx = bi_reg;
    assign best_ph  = bp_reg;
endmodule
`default_nettype wire

// ===== sv/spi_merge.sv =====
// Merge stage: compares the two lanes' peaks and forms status, Q16.16 ratio
// by a bit-serial restoring divider, and phase difference. Uses spi_pkg.
`default_nettype none
module spi_merge #(
    parameter int MW = 25,
    parameter int BW = 9
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [MW-1:0]        v_mag,
    input  wire logic [BW-1:0]        v_idx,
    input  wire logic [15:0]          v_ph,
    input  wire logic [MW-1:0]        c_mag,
    input  wire logic [BW-1:0]        c_idx,
    input  wire logic [15:0]          c_ph,
    output logic                      done,
    output logic [1:0]                status,
    output logic [BW-1:0]             peak_bin,
    output logic [31:0]               mag_ratio,
    output logic signed [16:0]        phase_diff
);
    import spi_pkg::*;

    localparam int NW  = MW + 16;
    localparam int QCW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [QCW-1:0]  cnt_reg, cnt_next;
    logic [NW-1:0]   num_reg, num_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [MW:0]     rem_reg, rem_next;
    logic [MW-1:0]   den_reg, den_next;
    logic [1:0]      st_reg, st_next;
    logic [BW-1:0]   pb_reg, pb_next;
    logic signed [16:0] pd_reg, pd_next;
    logic [MW:0]     rsh;

    assign rsh = {rem_reg[MW-1:0], num_reg[NW-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg; num_next = num_reg; quo_next = quo_reg;
        rem_next = rem_reg; den_next = den_reg;
        st_next = st_reg; pb_next = pb_reg; pd_next = pd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = QCW'(NW);
            num_next  = {v_mag, 16'h0000};
            den_next  = c_mag;
            rem_next  = '0;
            quo_next  = '0;
            pb_next   = v_idx;
            pd_next   = 17'(signed'(v_ph)) - 17'(signed'(c_ph));
            if (v_idx == '0 || c_idx == '0)
                st_next = ST_NO_PEAK;
            else if (v_idx != c_idx)
                st_next = ST_MISMATCH;
            else
                st_next = ST_MATCH;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - QCW'(1);
                num_next = {num_reg[NW-2:0], 1'b0};
                if (rsh >= {1'b0, den_reg})
                begin
                    rem_next = rsh - {1'b0, den_reg};
                    quo_next = {quo_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh;
                    quo_next = {quo_reg[NW-2:0], 1'b0};
                end
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next; num_reg <= num_next; quo_reg <= quo_next;
        rem_reg <= rem_next; den_reg <= den_next;
        st_reg <= st_next; pb_reg <= pb_next; pd_reg <= pd_next;
    end

    logic sat;
    assign sat = (den_reg == '0) || (quo_reg[NW-1:32] != '0);

    assign done       = done_reg;
    assign status     = st_reg;
    assign peak_bin   = pb_reg;
    assign mag_ratio  = (st_reg != ST_MATCH) ? 32'd0 : (sat ? 32'hFFFF_FFFF : quo_reg[31:0]);
    assign phase_diff = (st_reg != ST_MATCH) ? 17'sd0 : pd_reg;
endmodule
`default_nettype wire

// ===== sv/spectral_peak_impedance.sv =====
// spectral_peak_impedance: streams spectrum bins of a voltage and a current
// channel; one result per spectrum. Instantiates spi_lane (x2), spi_merge.
//
// Input channel (valid/ready): one bin per request, bins in order from 0,
// last_bin marks the end of a spectrum. Output channel (valid/ready): one
// result per spectrum carrying status, peak_bin, mag_ratio, phase_diff.
// Each bin is processed by two lanes in parallel; a lane runs an iterative
// square root (SAMPLE_WIDTH+1 steps) alongside a 16-step CORDIC, and a new
// bin is accepted only once both lanes are done with the one before it.
// On the last bin the merge stage runs a bit-serial Q16.16 divider of
// SAMPLE_WIDTH+17 steps after the lanes finish (at once when that bin lies
// past the window); out_valid rises once the divider is done and the output
// register is free, and the next bin can be accepted in the cycle it rises.
// A new bin is accepted while a result waits; only a further last bin
// waits for the output register to drain. Reset clears all tracking
// state; a stalled receiver simply holds the result valid.
// Bins at index SPECTRUM_BINS or beyond are ignored until the last mark.
`default_nettype none
module spectral_peak_impedance #(
    parameter int SPECTRUM_BINS = 512,
    parameter int SAMPLE_WIDTH  = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] volt_re,
    input  wire logic signed [SAMPLE_WIDTH-1:0] volt_im,
    input  wire logic signed [SAMPLE_WIDTH-1:0] curr_re,
    input  wire logic signed [SAMPLE_WIDTH-1:0] curr_im,
    input  wire logic                           last_bin,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          status,
    output logic [8:0]                          peak_bin,
    output logic [31:0]                         mag_ratio,
    output logic signed [16:0]                  phase_diff
);
    import spi_pkg::*;

    localparam int BW = $clog2(SPECTRUM_BINS + 1);
    localparam int MW = SAMPLE_WIDTH + 1;

    fsm_t state_reg, state_next;
    logic [BW-1:0] cnt_reg, cnt_next;
    logic          last_reg, last_next;
    logic          ovalid_reg, ovalid_next;
    logic [1:0]    ost_reg;
    logic [8:0]    opb_reg;
    logic [31:0]   orat_reg;
    logic signed [16:0] opd_reg;

    logic acc, active, v_done, c_done, lanes_done, clear_lanes, m_start, m_done;
    logic [MW-1:0] vm, cm;
    logic [BW-1:0] vi, ci;
    logic signed [15:0] vp, cp;
    logic [1:0] m_st;
    logic [BW-1:0] m_pb;
    logic [31:0] m_rat;
    logic signed [16:0] m_pd;

    assign acc        = in_valid && in_ready;
    assign active     = acc && (cnt_reg < BW'(SPECTRUM_BINS));
    assign lanes_done = v_done && c_done;

    spi_lane #(.SW(SAMPLE_WIDTH), .BW(BW)) u_volt (
        .clk(clk), .rst_n(rst_n), .start(active), .clear(clear_lanes),
        .track_en(cnt_reg >= BW'(2)), .zero_mag(cnt_reg == '0), .bin(cnt_reg),
        .re(volt_re), .im(volt_im), .done(v_done),
        .best_mag(vm), .best_idx(vi), .best_ph(vp));

    spi_lane #(.SW(SAMPLE_WIDTH), .BW(BW)) u_curr (
        .clk(clk), .rst_n(rst_n), .start(active), .clear(clear_lanes),
        .track_en(cnt_reg >= BW'(2)), .zero_mag(cnt_reg == '0), .bin(cnt_reg),
        .re(curr_re), .im(curr_im), .done(c_done),
        .best_mag(cm), .best_idx(ci), .best_ph(cp));

    spi_merge #(.MW(MW), .BW(BW)) u_merge (
        .clk(clk), .rst_n(rst_n), .start(m_start),
        .v_mag(vm), .v_idx(vi), .v_ph(vp),
        .c_mag(cm), .c_idx(ci), .c_ph(cp),
        .done(m_done), .status(m_st), .peak_bin(m_pb),
        .mag_ratio(m_rat), .phase_diff(m_pd));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (acc)
                    state_next = (active || last_bin) ? S_DIV : S_IDLE;
            S_DIV:
                if (!last_reg && lanes_done)
                    state_next = S_IDLE;
                else if (last_reg && m_done)
                    state_next = S_OUT;
            S_OUT:
                if (!ovalid_reg || out_ready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // S_DIV covers lane and merge work; merge follows any lane work on a last bin
    logic lanes_busy_reg, lanes_busy_next;
    always_comb
    begin
        in_ready    = (state_reg == S_IDLE) && !(last_bin && ovalid_reg && !out_ready);
        m_start     = 1'b0;
        clear_lanes = 1'b0;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        lanes_busy_next = lanes_busy_reg;
        ovalid_next = ovalid_reg && !out_ready;
        if (acc)
        begin
            last_next = last_bin;
            lanes_busy_next = active;
            if (active)
                cnt_next = cnt_reg + BW'(1);
            if (last_bin && !active)
                m_start = 1'b1;
        end
        if (state_reg == S_DIV && lanes_busy_reg && lanes_done)
        begin
            lanes_busy_next = 1'b0;
            if (last_reg)
                m_start = 1'b1;
        end
        if (state_reg == S_OUT && (!ovalid_reg || out_ready))
        begin
            ovalid_next = 1'b1;
            clear_lanes = 1'b1;
            cnt_next    = '0;
        end
        case (state_reg)
            S_IDLE, S_DIV, S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            last_reg <= 1'b0;
            lanes_busy_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            last_reg <= last_next;
            lanes_busy_reg <= lanes_busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!ovalid_reg || out_ready))
        begin
            ost_reg  <= m_st;
            opb_reg  <= 9'(m_pb);
            orat_reg <= m_rat;
            opd_reg  <= m_pd;
        end
    end

    assign out_valid  = ovalid_reg;
    assign status     = ost_reg;
    assign peak_bin   = opb_reg;
    assign mag_ratio  = orat_reg;
    assign phase_diff = opd_reg;
endmodule
`default_nettype wire

// ===== verif/spectral_peak_impedance_tb.sv =====
// Testbench for spectral_peak_impedance: directed spectra from a table, then random
// spectra, checked by table or in-file predictor. Depends on spi_pkg and the RTL.
`default_nettype none
module spectral_peak_impedance_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import spi_pkg::*;

    localparam int NBINS      = 512;
    localparam int N_ITEMS    = 1850;
    localparam int QUIET_FROM = 1650;
    localparam int HOLD_CYC   = 2000;
    localparam int WD_LIMIT   = 6000;
    localparam logic signed [23:0] SMAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SMIN = 24'sh800000;

    typedef struct {
        status_t            st;
        logic [8:0]         bin;
        logic [31:0]        ratio;
        logic signed [16:0] pd;
    } peak_result_t;

    typedef struct {
        logic signed [23:0] vre, vim, cre, cim;
        logic               last;
        bit                 typed;
        peak_result_t       res;
    } bin_row_t;

    typedef struct {
        longint unsigned mag;
        int              idx;
        int              ph;
    } best_peak_t;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0, in_ready;
    logic signed [23:0] volt_re = 0, volt_im = 0, curr_re = 0, curr_im = 0;
    logic last_bin = 0;
    logic out_valid, out_ready = 0;
    logic [1:0] status;
    logic [8:0] peak_bin;
    logic [31:0] mag_ratio;
    logic signed [16:0] phase_diff;

    spectral_peak_impedance dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .volt_re(volt_re), .volt_im(volt_im), .curr_re(curr_re), .curr_im(curr_im),
        .last_bin(last_bin),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .peak_bin(peak_bin), .mag_ratio(mag_ratio),
        .phase_diff(phase_diff)
    );

    always #5 clk = ~clk;

    peak_result_t pending_results[$];
    int errors = 0;
    int results_seen = 0;
    int bins_sent = 0;
    bit quiet = 0;

    // predictor state
    int              bin_idx;
    longint unsigned v_prev[2], c_prev[2];
    int              v_prev_ph, c_prev_ph;
    best_peak_t      v_best, c_best;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned bin_mag(longint re, longint im);
        longint a, b;
        a = re < 0 ? -re : re;
        b = im < 0 ? -im : im;
        return int_sqrt(a * a + b * b);
    endfunction

    function automatic int angle_step(int i);
        int t[16];
        t = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
        return t[i];
    endfunction

    function automatic int bin_phase(longint re, longint im);
        longint x, y, dx, dy;
        int z;
        logic signed [15:0] w;
        z = 0;
        if (im == 0) return re >= 0 ? 0 : -32768;
        if (re == 0) return im > 0 ? 16384 : -16384;
        x = re * 256;
        y = im * 256;
        if (x < 0)
        begin
            z = (y >= 0) ? 32768 : -32768;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += angle_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= angle_step(i);
            end
        end
        w = z[15:0];
        return int'(w);
    endfunction

    function automatic void clear_tracking();
        bin_idx = 0;
        v_prev = '{0, 0};
        c_prev = '{0, 0};
        v_prev_ph = 0;
        c_prev_ph = 0;
        v_best = '{0, 0, 0};
        c_best = '{0, 0, 0};
    endfunction

    function automatic void track_peak(ref longint unsigned prev[2], input int prev_ph,
                                       ref best_peak_t best, input longint unsigned cur);
        if (bin_idx >= 2 && prev[1] < prev[0] && prev[0] > cur && prev[0] > best.mag)
        begin
            best.mag = prev[0];
            best.idx = bin_idx - 1;
            best.ph  = prev_ph;
        end
    endfunction

    // Absorbs one accepted bin; returns 1 with the spectrum result on the last bin.
    function automatic bit absorb_bin(bin_row_t r, output peak_result_t res);
        longint unsigned vm, cm, q;
        vm = 0;
        cm = 0;
        res = '{ST_NO_PEAK, 9'd0, 32'd0, 17'sd0};
        if (bin_idx < NBINS)
        begin
            if (bin_idx != 0)
            begin
                vm = bin_mag(r.vre, r.vim);
                cm = bin_mag(r.cre, r.cim);
            end
            track_peak(v_prev, v_prev_ph, v_best, vm);
            track_peak(c_prev, c_prev_ph, c_best, cm);
            v_prev[1] = v_prev[0]; v_prev[0] = vm;
            c_prev[1] = c_prev[0]; c_prev[0] = cm;
            v_prev_ph = bin_phase(r.vre, r.vim);
            c_prev_ph = bin_phase(r.cre, r.cim);
            bin_idx++;
        end
        if (!r.last) return 0;
        res.bin = v_best.idx[8:0];
        if (v_best.idx == 0 || c_best.idx == 0)
            res.st = ST_NO_PEAK;
        else if (v_best.idx != c_best.idx)
            res.st = ST_MISMATCH;
        else
        begin
            res.st = ST_MATCH;
            if (c_best.mag == 0)
                q = 64'hFFFF_FFFF;
            else
                q = (v_best.mag << 16) / c_best.mag;
            res.ratio = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
            res.pd = 17'(v_best.ph - c_best.ph);
        end
        clear_tracking();
        return 1;
    endfunction

    // Drives one request; called at a falling edge, returns at a falling edge.
    task automatic send_bin(bin_row_t r);
        peak_result_t res;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1;
        volt_re  <= r.vre;
        volt_im  <= r.vim;
        curr_re  <= r.cre;
        curr_im  <= r.cim;
        last_bin <= r.last;
        do @(posedge clk); while (!in_ready);
        if (absorb_bin(r, res))
            pending_results.push_back(r.typed ? r.res : res);
        bins_sent++;
        if (bins_sent >= QUIET_FROM) quiet = 1;
        @(negedge clk);
    endtask

    function automatic logic signed [23:0] rnd_in(int amp);
        return 24'($signed($urandom_range(0, 2 * amp)) - amp);
    endfunction

    // Spectrum with a planted peak per channel (or pure noise when noisy is set).
    task automatic send_spectrum(int len, bit noisy, bit same_peak);
        bin_row_t r;
        int vp, cp, big_v, big_c;
        vp = len > 2 ? $urandom_range(1, len - 2) : 1;
        cp = same_peak ? vp : (len > 2 ? $urandom_range(1, len - 2) : 1);
        big_v = ($urandom_range(0, 3) == 0) ? 8388607 : $urandom_range(8, 4000000);
        big_c = ($urandom_range(0, 3) == 0) ? 8388607 : $urandom_range(8, 4000000);
        for (int k = 0; k < len; k++)
        begin
            r.typed = 0;
            r.res   = '{ST_NO_PEAK, 9'd0, 32'd0, 17'sd0};
            r.last  = (k == len - 1);
            if (noisy || k == 0)
            begin
                r.vre = 24'($urandom); r.vim = 24'($urandom);
                r.cre = 24'($urandom); r.cim = 24'($urandom);
            end
            else
            begin
                r.vre = rnd_in(big_v / 4); r.vim = rnd_in(big_v / 4);
                r.cre = rnd_in(big_c / 4); r.cim = rnd_in(big_c / 4);
                if (k == vp)
                begin
                    r.vre = $urandom_range(0, 1) ? 24'(big_v) : 24'(-big_v);
                    r.vim = rnd_in(big_v / 8);
                end
                if (k == cp)
                begin
                    r.cre = rnd_in(big_c / 8);
                    r.cim = $urandom_range(0, 1) ? 24'(big_c) : 24'(-big_c);
                end
            end
            send_bin(r);
        end
    endtask

    bin_row_t directed[] = '{
        // single-bin spectrum: nothing to find
        '{SMAX, 0, SMIN, 0, 1, 1, '{ST_NO_PEAK, 0, 0, 0}},
        // bin zero is counted as zero magnitude, two bins give no peak
        '{SMIN, SMIN, SMIN, SMIN, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{1, 1, 1, 1, 1, 1, '{ST_NO_PEAK, 0, 0, 0}},
        // real axis phases, both signs
        '{0, 0, 0, 0, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{100, 0, -100, 0, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{1, 0, 1, 0, 1, 1, '{ST_MATCH, 1, 32'd65536, 17'sd32768}},
        // imaginary axis phases
        '{0, 0, 0, 0, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{0, 200, 0, -100, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{0, 1, 0, 1, 1, 1, '{ST_MATCH, 1, 32'd131072, 17'sd32768}},
        // equal peaks keep the earlier bin; current peaks elsewhere
        '{0, 0, 0, 0, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{5, 0, 1, 0, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{1, 0, 7, 0, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{5, 0, 1, 0, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{1, 0, 1, 0, 1, 1, '{ST_MISMATCH, 1, 0, 0}},
        // full-scale corners
        '{SMIN, SMIN, SMAX, SMAX, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{SMIN, SMIN, 1, -1, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{1, 1, SMIN, SMAX, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{0, 0, 0, 0, 1, 0, '{ST_NO_PEAK, 0, 0, 0}},
        // ratio saturates
        '{0, 0, 0, 0, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{SMIN, SMIN, 1, 0, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{0, 0, 0, 0, 1, 0, '{ST_NO_PEAK, 0, 0, 0}},
        // ratio rounds down to zero
        '{0, 0, 0, 0, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{1, 0, SMAX, SMIN, 0, 0, '{ST_NO_PEAK, 0, 0, 0}},
        '{0, 0, 0, 0, 1, 0, '{ST_NO_PEAK, 0, 0, 0}}
    };

    initial
    begin
        int s, len;
        clear_tracking();
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(negedge clk);
        foreach (directed[i]) send_bin(directed[i]);
        s = 0;
        while (bins_sent < N_ITEMS)
        begin
            if (s == 10)      len = 530;   // runs past the bin window
            else if (s == 25) len = NBINS;
            else if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 2);
            else len = $urandom_range(3, 24);
            send_spectrum(len, $urandom_range(0, 4) == 0, $urandom_range(0, 3) != 0);
            s++;
        end
        in_valid <= 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("spectral_peak_impedance_tb: done, clean");
        else
            $display("spectral_peak_impedance_tb: done, errors");
        $finish;
    end

    // receiver: random stalls, one long hold-off so the input backs up
    initial
    begin
        bit held;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && results_seen == 5)
            begin
                out_ready <= 0;
                repeat (HOLD_CYC) @(negedge clk);
                held = 1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            out_ready <= 1;
        end
    end

    always @(posedge clk)
    begin
        peak_result_t e;
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d bin %0d", status, peak_bin);
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st || peak_bin !== e.bin || mag_ratio !== e.ratio
                    || phase_diff !== e.pd)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"result %0d: exp st %0d bin %0d ratio %h pd %0d,",
                                  " got st %0d bin %0d ratio %h pd %0d"},
                                 results_seen, e.st, e.bin, e.ratio, e.pd,
                                 status, peak_bin, mag_ratio, phase_diff);
                end
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("spectral_peak_impedance_tb: done, errors");
            $finish;
        end
    end
endmodule
`default_nettype wire
